// ----- src/dstf_pkg.sv -----
// dstf_pkg: shared constants, types and the power-of-ten table for the
// decimal string to fixed point converter
// no dependencies
package dstf_pkg;

  localparam int FRAC_BITS       = 32;
  localparam int MAX_FRAC_DIGITS = 19;
  localparam int INT_BITS        = 32;
  localparam int CNT_W           = (FRAC_BITS > 1) ? $clog2(FRAC_BITS) : 1;
  localparam int FCNT_W          = $clog2(MAX_FRAC_DIGITS + 1);

  localparam logic [1:0] ST_VALID   = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_SAT     = 2'd2;

  typedef struct packed {
    logic take;
    logic prep;
    logic div_step;
    logic fin_load;
  } dstf_cmd_t;

  function automatic logic [63:0] pow10(input logic [FCNT_W-1:0] k);
    logic [63:0] p;
    case (5'(k))
      5'd0:    p = 64'd1;
      5'd1:    p = 64'd10;
      5'd2:    p = 64'd100;
      5'd3:    p = 64'd1000;
      5'd4:    p = 64'd10000;
      5'd5:    p = 64'd100000;
      5'd6:    p = 64'd1000000;
      5'd7:    p = 64'd10000000;
      5'd8:    p = 64'd100000000;
      5'd9:    p = 64'd1000000000;
      5'd10:   p = 64'd10000000000;
      5'd11:   p = 64'd100000000000;
      5'd12:   p = 64'd1000000000000;
      5'd13:   p = 64'd10000000000000;
      5'd14:   p = 64'd100000000000000;
      5'd15:   p = 64'd1000000000000000;
      5'd16:   p = 64'd10000000000000000;
      5'd17:   p = 64'd100000000000000000;
      5'd18:   p = 64'd1000000000000000000;
      5'd19:   p = 64'd10000000000000000000;
      default: p = 64'd1;
    endcase
    return p;
  endfunction

endpackage

// ----- src/dstf_ctrl.sv -----
// dstf_ctrl: sequencing state machine for the converter
// issues commands to dstf_dp, owns the handshakes; depends on dstf_pkg
module dstf_ctrl
  import dstf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      in_last,
  output logic      out_valid,
  input  logic      out_ready,
  output dstf_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_RUN,
    S_PREP,
    S_DIV,
    S_FIN
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign in_ready  = (state_r == S_RUN);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      S_RUN: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          if (in_last) state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        cnt_nxt   = CNT_W'(FRAC_BITS - 1);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) state_nxt = S_FIN;
        else cnt_nxt = cnt_r - 1'b1;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.fin_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_RUN;
        end
      end
      default: state_nxt = S_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RUN;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_prep_to_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PREP |=> state_r == S_DIV)
    else $error("prep not followed by division");

  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && cnt_r == '0) |=> state_r == S_FIN)
    else $error("division did not end after its last step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin_load |-> (!out_valid_r || out_ready))
    else $error("result loaded over an untaken one");

  a_take_only_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |-> (in_ready && in_valid))
    else $error("character taken without a request");

endmodule

// ----- src/dstf_dp.sv -----
// dstf_dp: parser registers, accumulators, fraction divider and result register
// driven by commands from dstf_ctrl; depends on dstf_pkg
module dstf_dp
  import dstf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  dstf_cmd_t          cmd,
  input  logic [7:0]         in_char_code,
  output logic signed [63:0] out_value,
  output logic [1:0]         out_status
);

  typedef enum logic [2:0] {
    PH_WS   = 3'd0,
    PH_SIGN = 3'd1,
    PH_INT  = 3'd2,
    PH_DOT  = 3'd3,
    PH_FRAC = 3'd4,
    PH_OK   = 3'd5,
    PH_BAD  = 3'd6
  } phase_t;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;
  localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

  phase_t                phase_r, phase_nxt;
  logic                  neg_r, neg_nxt;
  logic [INT_BITS-1:0]   int_r, int_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [63:0]           frac_r, frac_nxt;
  logic [FCNT_W-1:0]     fcnt_r, fcnt_nxt;

  logic [63:0]           den_r, rem_r;
  logic [FRAC_BITS-1:0]  quo_r;
  logic [63:0]           out_value_r;
  logic [1:0]            out_status_r;

  logic                  is_digit, is_space;
  logic [3:0]            digit;
  logic [INT_BITS+3:0]   int_x10;
  logic [63:0]           frac_x10;
  logic [63:0]           den_sel;
  logic [64:0]           rem_x2;
  logic [63:0]           mag;
  logic                  parse_ok;
  logic [63:0]           fin_value;
  logic [1:0]            fin_status;

  assign is_digit = (in_char_code >= CH_ZERO) && (in_char_code <= CH_NINE);
  assign is_space = (in_char_code == CH_SPACE) ||
                    ((in_char_code >= CH_TAB) && (in_char_code <= CH_CR));
  assign digit    = in_char_code[3:0];

  assign int_x10  = {1'b0, int_r, 3'b000} + {3'b000, int_r, 1'b0} + (INT_BITS+4)'(digit);
  assign frac_x10 = {frac_r[60:0], 3'b000} + {frac_r[62:0], 1'b0} + 64'(digit);

  // parse step on each taken character, clear when the result is loaded
  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    int_nxt   = int_r;
    ovf_nxt   = ovf_r;
    frac_nxt  = frac_r;
    fcnt_nxt  = fcnt_r;
    if (cmd.take) begin
      unique case (phase_r) inside
        PH_WS, PH_SIGN: begin
          if (is_digit) begin
            phase_nxt = PH_INT;
          end else if (phase_r == PH_WS && is_space) begin
            phase_nxt = PH_WS;
          end else if (phase_r == PH_WS && in_char_code == CH_MINUS) begin
            neg_nxt   = 1'b1;
            phase_nxt = PH_SIGN;
          end else begin
            phase_nxt = PH_BAD;
          end
        end
        PH_INT: begin
          if (!is_digit) phase_nxt = (in_char_code == CH_DOT) ? PH_DOT : PH_OK;
        end
        PH_DOT: phase_nxt = is_digit ? PH_FRAC : PH_BAD;
        PH_FRAC: begin
          if (!is_digit) phase_nxt = PH_OK;
        end
        PH_OK, PH_BAD: phase_nxt = phase_r;
        default: phase_nxt = PH_BAD;
      endcase
      if (is_digit && (phase_r == PH_WS || phase_r == PH_SIGN || phase_r == PH_INT)) begin
        if (int_x10[INT_BITS+3:INT_BITS] != '0) begin
          int_nxt = '1;
          ovf_nxt = 1'b1;
        end else begin
          int_nxt = int_x10[INT_BITS-1:0];
        end
      end
      if (is_digit && (phase_r == PH_DOT || phase_r == PH_FRAC) &&
          (fcnt_r < FCNT_W'(MAX_FRAC_DIGITS))) begin
        frac_nxt = frac_x10;
        fcnt_nxt = fcnt_r + 1'b1;
      end
    end
    if (cmd.fin_load) begin
      phase_nxt = PH_WS;
      neg_nxt   = 1'b0;
      int_nxt   = '0;
      ovf_nxt   = 1'b0;
      frac_nxt  = '0;
      fcnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WS;
      neg_r   <= 1'b0;
      int_r   <= '0;
      ovf_r   <= 1'b0;
      frac_r  <= '0;
      fcnt_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      int_r   <= int_nxt;
      ovf_r   <= ovf_nxt;
      frac_r  <= frac_nxt;
      fcnt_r  <= fcnt_nxt;
    end
  end

  // restoring division of the fraction by 10^k, one quotient bit per step
  assign den_sel = pow10(fcnt_r);
  assign rem_x2  = {rem_r, 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      den_r <= den_sel;
      rem_r <= (frac_r >= den_sel) ? (den_sel - 64'd1) : frac_r;
      quo_r <= '0;
    end else if (cmd.div_step) begin
      if (rem_x2 >= {1'b0, den_r}) begin
        rem_r <= 64'(rem_x2 - {1'b0, den_r});
        quo_r <= {quo_r[FRAC_BITS-2:0], 1'b1};
      end else begin
        rem_r <= rem_x2[63:0];
        quo_r <= {quo_r[FRAC_BITS-2:0], 1'b0};
      end
    end
  end

  // sign, clamp and status
  assign mag      = 64'({int_r, quo_r});
  assign parse_ok = (phase_r == PH_INT) || (phase_r == PH_FRAC) || (phase_r == PH_OK);

  always_comb begin
    fin_status = ovf_r ? ST_SAT : ST_VALID;
    fin_value  = '0;
    if (!parse_ok) begin
      fin_status = ST_INVALID;
    end else if (neg_r) begin
      if (mag > NEG_LIMIT) begin
        fin_value  = NEG_LIMIT;
        fin_status = ST_SAT;
      end else begin
        fin_value = ~mag + 64'd1;
      end
    end else begin
      if (mag > POS_LIMIT) begin
        fin_value  = POS_LIMIT;
        fin_status = ST_SAT;
      end else begin
        fin_value = mag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_load) begin
      out_value_r  <= fin_value;
      out_status_r <= fin_status;
    end
  end

  assign out_value  = $signed(out_value_r);
  assign out_status = out_status_r;

  a_frac_count: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= FCNT_W'(MAX_FRAC_DIGITS))
    else $error("fraction digit count past its limit");

  a_frac_bound: assert property (@(posedge clk) disable iff (!rst_n)
    frac_r < pow10(fcnt_r))
    else $error("fraction accumulator exceeds its digit count");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> rem_r < den_r)
    else $error("division remainder not below divisor");

endmodule

// ----- src/decimal_string_to_fixed.sv -----
// decimal_string_to_fixed: decimal text to signed Q31.32 converter, top level
// a character without last is taken at once; one with last blocks input through
// setup, one division step per quotient bit, then sign, clamp and load; the
// load, and so the result, waits while the previous result still sits in the
// result register
// reset: synchronous, active low, clears parser and control; needs dstf_pkg, dstf_ctrl, dstf_dp
module decimal_string_to_fixed
  import dstf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_char_code,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] out_value,
  output logic [1:0]         out_status
);

  dstf_cmd_t cmd;

  dstf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  dstf_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_char_code (in_char_code),
    .out_value    (out_value),
    .out_status   (out_status)
  );

endmodule
